[rtl/core/aarm_pkg.sv]
// shared types, widths and fixed-point helpers for the axis-angle rotation matrix core
// no dependencies; used by aarm_norm and axis_angle_rotation_matrix_core
package aarm_pkg;

  localparam int F = 15;                       // fraction bits, one is 2**F
  localparam int QW = 2 * F + 1;               // width of the squared unit component
  localparam int DS = 2 * F + 1;               // divider steps
  localparam int SS = F + 1;                   // square root steps
  localparam int RW = F + 5;                   // square root remainder width
  localparam int UW = F + 2;                   // signed unit component width
  localparam int OW = (F + 3 > 19) ? F + 3 : 19;  // product operand width
  localparam int PW = 2 * OW;

  typedef logic signed [OW-1:0] op_t;
  typedef logic [PW-1:0] prod_t;

  typedef struct packed {
    logic signed [15:0] cos_v;
    logic signed [15:0] sin_v;
    logic               zero;
  } side_t;

  // a*b / 2**F, rounded to nearest, ties away from zero
  function automatic op_t rmul(input op_t a, input op_t b);
    logic  neg;
    op_t   ma;
    op_t   mb;
    prod_t p;
    prod_t r;
    neg = a[OW-1] ^ b[OW-1];
    ma = a[OW-1] ? -a : a;
    mb = b[OW-1] ? -b : b;
    p = PW'(unsigned'(ma)) * PW'(unsigned'(mb));
    r = (p + (PW'(1) << (F - 1))) >> F;
    rmul = neg ? -op_t'(r[OW-1:0]) : op_t'(r[OW-1:0]);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [OW:0] v);
    logic signed [OW:0] hi;
    logic signed [OW:0] lo;
    hi = (OW+1)'(32767);
    lo = -(OW+1)'(32768);
    if (v > hi) sat16 = 16'sh7fff;
    else if (v < lo) sat16 = -16'sh8000;
    else sat16 = v[15:0];
  endfunction

endpackage

[rtl/core/aarm_norm.sv]
// axis normalization pipeline: squares, norm, bit-serial divider stages, square root stages
// depends on aarm_pkg
module aarm_norm (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      valid_in,
  input  logic signed [15:0]        cos_in,
  input  logic signed [15:0]        sin_in,
  input  logic signed [15:0]        ax,
  input  logic signed [15:0]        ay,
  input  logic signed [15:0]        az,
  output logic                      valid_out,
  output aarm_pkg::side_t           side_out,
  output logic signed [aarm_pkg::UW-1:0] ux,
  output logic signed [aarm_pkg::UW-1:0] uy,
  output logic signed [aarm_pkg::UW-1:0] uz
);
  import aarm_pkg::*;

  // squares stage
  logic [31:0] sq [3];
  logic [2:0]  sneg;
  side_t       sside;
  logic        sv;
  // norm stage
  logic [31:0] na2 [3];
  logic [31:0] nn2;
  logic [2:0]  nneg;
  side_t       nside;
  logic        nv;
  // divider stages
  logic [32:0]   dr [DS][3];
  logic [QW-1:0] dq [DS][3];
  logic [31:0]   dn2 [DS];
  logic [2:0]    dneg [DS];
  side_t         dside [DS];
  logic          dv [DS];
  // square root stages
  logic [QW:0]   tq [SS][3];
  logic [RW-1:0] trem [SS][3];
  logic [F:0]    troot [SS][3];
  logic [2:0]    tneg [SS];
  side_t         tside [SS];
  logic          tv [SS];

  logic [15:0] amag [3];
  logic [2:0]  aneg;

  always_comb begin
    aneg = {az[15], ay[15], ax[15]};
    amag[0] = ax[15] ? 16'(-ax) : 16'(ax);
    amag[1] = ay[15] ? 16'(-ay) : 16'(ay);
    amag[2] = az[15] ? 16'(-az) : 16'(az);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= 1'b0;
      nv <= 1'b0;
    end else if (en) begin
      sv <= valid_in;
      nv <= sv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq[i] <= 32'(amag[i]) * 32'(amag[i]);
        na2[i] <= sq[i];
      end
      sneg <= aneg;
      sside <= '{cos_v: cos_in, sin_v: sin_in, zero: 1'b0};
      nn2 <= sq[0] + sq[1] + sq[2];
      nneg <= sneg;
      nside <= '{cos_v: sside.cos_v, sin_v: sside.sin_v,
                 zero: (sq[0] | sq[1] | sq[2]) == 32'd0};
    end
  end

  genvar k;
  generate
    for (k = 0; k < DS; k++) begin : g_div
      logic [32:0]   rin [3];
      logic [QW-1:0] qin [3];
      logic [31:0]   n2in;
      logic [2:0]    negin;
      side_t         sidein;
      logic          vin;
      logic [32:0]   rout [3];
      logic [QW-1:0] qout [3];

      if (k == 0) begin : g_first
        always_comb begin
          for (int i = 0; i < 3; i++) begin
            rin[i] = {1'b0, na2[i]};
            qin[i] = '0;
          end
          n2in = nn2;
          negin = nneg;
          sidein = nside;
          vin = nv;
        end
      end else begin : g_next
        always_comb begin
          for (int i = 0; i < 3; i++) begin
            rin[i] = {dr[k-1][i][31:0], 1'b0};
            qin[i] = dq[k-1][i];
          end
          n2in = dn2[k-1];
          negin = dneg[k-1];
          sidein = dside[k-1];
          vin = dv[k-1];
        end
      end

      always_comb begin
        for (int i = 0; i < 3; i++) begin
          if (rin[i] >= {1'b0, n2in}) begin
            rout[i] = rin[i] - {1'b0, n2in};
            qout[i] = {qin[i][QW-2:0], 1'b1};
          end else begin
            rout[i] = rin[i];
            qout[i] = {qin[i][QW-2:0], 1'b0};
          end
        end
      end

      always_ff @(posedge clk) begin
        if (rst) dv[k] <= 1'b0;
        else if (en) dv[k] <= vin;
      end

      always_ff @(posedge clk) begin
        if (en) begin
          for (int i = 0; i < 3; i++) begin
            dr[k][i] <= rout[i];
            dq[k][i] <= qout[i];
          end
          dn2[k] <= n2in;
          dneg[k] <= negin;
          dside[k] <= sidein;
        end
      end
    end

    for (k = 0; k < SS; k++) begin : g_sqrt
      logic [QW:0]   qin [3];
      logic [RW-1:0] remin [3];
      logic [F:0]    rootin [3];
      logic [2:0]    negin;
      side_t         sidein;
      logic          vin;
      logic [RW-1:0] remsh [3];
      logic [RW-1:0] trial [3];
      logic [RW-1:0] remout [3];
      logic [F:0]    rootout [3];

      if (k == 0) begin : g_first
        always_comb begin
          for (int i = 0; i < 3; i++) begin
            qin[i] = {1'b0, dq[DS-1][i]};
            remin[i] = '0;
            rootin[i] = '0;
          end
          negin = dneg[DS-1];
          sidein = dside[DS-1];
          vin = dv[DS-1];
        end
      end else begin : g_next
        always_comb begin
          for (int i = 0; i < 3; i++) begin
            qin[i] = tq[k-1][i];
            remin[i] = trem[k-1][i];
            rootin[i] = troot[k-1][i];
          end
          negin = tneg[k-1];
          sidein = tside[k-1];
          vin = tv[k-1];
        end
      end

      // one result bit per step, two radicand bits brought down
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          remsh[i] = {remin[i][RW-3:0], qin[i][2*(F-k)+1 -: 2]};
          trial[i] = RW'({rootin[i], 2'b01});
          if (remsh[i] >= trial[i]) begin
            remout[i] = remsh[i] - trial[i];
            rootout[i] = {rootin[i][F-1:0], 1'b1};
          end else begin
            remout[i] = remsh[i];
            rootout[i] = {rootin[i][F-1:0], 1'b0};
          end
        end
      end

      always_ff @(posedge clk) begin
        if (rst) tv[k] <= 1'b0;
        else if (en) tv[k] <= vin;
      end

      always_ff @(posedge clk) begin
        if (en) begin
          for (int i = 0; i < 3; i++) begin
            tq[k][i] <= qin[i];
            trem[k][i] <= remout[i];
            troot[k][i] <= rootout[i];
          end
          tneg[k] <= negin;
          tside[k] <= sidein;
        end
      end
    end
  endgenerate

  always_comb begin
    valid_out = tv[SS-1];
    side_out = tside[SS-1];
    ux = tneg[SS-1][0] ? -UW'(troot[SS-1][0]) : UW'(troot[SS-1][0]);
    uy = tneg[SS-1][1] ? -UW'(troot[SS-1][1]) : UW'(troot[SS-1][1]);
    uz = tneg[SS-1][2] ? -UW'(troot[SS-1][2]) : UW'(troot[SS-1][2]);
  end

endmodule

[rtl/core/axis_angle_rotation_matrix_core.sv]
// rodrigues rotation matrix from cosine, sine and an unnormalized axis, Q1.15 saturated
// depends on aarm_pkg and aarm_norm
// pipeline stages: squares, norm, 2F+1 divider, F+1 root, 3 product stages
// throughput: one beat per cycle unless the output stalls; each divider or root stage is one step
// a stalled output holds the whole pipeline; in_ready is low only while out_valid waits
// reset: synchronous, clears all stage valid bits; payload registers are not reset
module axis_angle_rotation_matrix_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] cos_value,
  input  logic signed [15:0] sin_value,
  input  logic signed [15:0] axis_x,
  input  logic signed [15:0] axis_y,
  input  logic signed [15:0] axis_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] entry_r0c0,
  output logic signed [15:0] entry_r0c1,
  output logic signed [15:0] entry_r0c2,
  output logic signed [15:0] entry_r1c0,
  output logic signed [15:0] entry_r1c1,
  output logic signed [15:0] entry_r1c2,
  output logic signed [15:0] entry_r2c0,
  output logic signed [15:0] entry_r2c1,
  output logic signed [15:0] entry_r2c2,
  output logic               zero_axis_flag
);
  import aarm_pkg::*;

  logic            en;
  logic            nv;
  side_t           nside;
  logic signed [UW-1:0] ux, uy, uz;

  // first product stage
  logic  m1v;
  side_t m1side;
  op_t   pxx, pyy, pzz, pxy, pxz, pyz, xs1, ys1, zs1, cc1;
  // second product stage
  logic  m2v;
  side_t m2side;
  op_t   xx, yy, zz, xy, xz, yz, xs, ys, zs;

  logic signed [OW:0] cw;

  assign en = !out_valid || out_ready;
  assign in_ready = en;

  aarm_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (in_valid),
    .cos_in    (cos_value),
    .sin_in    (sin_value),
    .ax        (axis_x),
    .ay        (axis_y),
    .az        (axis_z),
    .valid_out (nv),
    .side_out  (nside),
    .ux        (ux),
    .uy        (uy),
    .uz        (uz)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m1v <= 1'b0;
      m2v <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      m1v <= nv;
      m2v <= m1v;
      out_valid <= m2v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pxx <= rmul(OW'(ux), OW'(ux));
      pyy <= rmul(OW'(uy), OW'(uy));
      pzz <= rmul(OW'(uz), OW'(uz));
      pxy <= rmul(OW'(ux), OW'(uy));
      pxz <= rmul(OW'(ux), OW'(uz));
      pyz <= rmul(OW'(uy), OW'(uz));
      xs1 <= rmul(OW'(ux), OW'(nside.sin_v));
      ys1 <= rmul(OW'(uy), OW'(nside.sin_v));
      zs1 <= rmul(OW'(uz), OW'(nside.sin_v));
      cc1 <= (op_t'(1) <<< F) - OW'(nside.cos_v);
      m1side <= nside;

      xx <= rmul(pxx, cc1);
      yy <= rmul(pyy, cc1);
      zz <= rmul(pzz, cc1);
      xy <= rmul(pxy, cc1);
      xz <= rmul(pxz, cc1);
      yz <= rmul(pyz, cc1);
      xs <= xs1;
      ys <= ys1;
      zs <= zs1;
      m2side <= m1side;
    end
  end

  assign cw = (OW+1)'(m2side.cos_v);

  // zero axis forces every entry to zero
  always_ff @(posedge clk) begin
    if (en) begin
      zero_axis_flag <= m2side.zero;
      if (m2side.zero) begin
        entry_r0c0 <= '0;
        entry_r0c1 <= '0;
        entry_r0c2 <= '0;
        entry_r1c0 <= '0;
        entry_r1c1 <= '0;
        entry_r1c2 <= '0;
        entry_r2c0 <= '0;
        entry_r2c1 <= '0;
        entry_r2c2 <= '0;
      end else begin
        entry_r0c0 <= sat16(cw + (OW+1)'(xx));
        entry_r0c1 <= sat16((OW+1)'(xy) - (OW+1)'(zs));
        entry_r0c2 <= sat16((OW+1)'(xz) + (OW+1)'(ys));
        entry_r1c0 <= sat16((OW+1)'(xy) + (OW+1)'(zs));
        entry_r1c1 <= sat16(cw + (OW+1)'(yy));
        entry_r1c2 <= sat16((OW+1)'(yz) - (OW+1)'(xs));
        entry_r2c0 <= sat16((OW+1)'(xz) - (OW+1)'(ys));
        entry_r2c1 <= sat16((OW+1)'(yz) + (OW+1)'(xs));
        entry_r2c2 <= sat16(cw + (OW+1)'(zz));
      end
    end
  end

endmodule

[rtl/core/aarm_checker.sv]
// port-level assertions for axis_angle_rotation_matrix_core, bound to the top level
// depends on axis_angle_rotation_matrix_core ports only
module aarm_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] entry_r0c0,
  input logic signed [15:0] entry_r1c1,
  input logic signed [15:0] entry_r2c2,
  input logic signed [15:0] entry_r0c1,
  input logic               zero_axis_flag
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid after reset");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_axis_flag |->
      entry_r0c0 == 16'sd0 && entry_r1c1 == 16'sd0 && entry_r2c2 == 16'sd0 &&
      entry_r0c1 == 16'sd0)
    else $error("zero axis beat with nonzero entries");

endmodule

bind axis_angle_rotation_matrix_core aarm_checker u_aarm_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .entry_r0c0     (entry_r0c0),
  .entry_r1c1     (entry_r1c1),
  .entry_r2c2     (entry_r2c2),
  .entry_r0c1     (entry_r0c1),
  .zero_axis_flag (zero_axis_flag)
);
